[design/shortlex_index_to_word_macros.svh]
// Assertion macros for the shortlex index-to-word block.
`ifndef SHORTLEX_INDEX_TO_WORD_MACROS_SVH
`define SHORTLEX_INDEX_TO_WORD_MACROS_SVH

`ifndef ASSERT_OFF
`define SLW_ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SLW_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SLW_ASSERT_CLK(lbl, prop, msg)
`define SLW_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

[design/slw_pkg.sv]
// Constants, types and helper functions for the shortlex index-to-word block.
package slw_pkg;

  localparam int INDEX_BITS   = 48;
  localparam int MAX_ALPHABET = 16;
  localparam int SYM_W        = 8;
  localparam int K_W          = $clog2(MAX_ALPHABET + 1);
  localparam int DIG_W        = $clog2(MAX_ALPHABET);
  localparam int PW_W         = INDEX_BITS + DIG_W;
  localparam int LEN_W        = $clog2(INDEX_BITS + 1);
  localparam int POS_W        = $clog2(INDEX_BITS);
  localparam int SLICE        = 8;
  localparam int DIV_CYCLES   = (INDEX_BITS + SLICE - 1) / SLICE;
  localparam int DIV_W        = DIV_CYCLES * SLICE;
  localparam int STEP_W       = $clog2(DIV_CYCLES + 1);

  localparam int CFG_AW = 5;
  localparam int CFG_DW = 64;

  localparam logic [1:0] REG_ALPHABET_SIZE = 2'd0;
  localparam logic [1:0] REG_ALPHABET_LOW  = 2'd1;
  localparam logic [1:0] REG_ALPHABET_HIGH = 2'd2;

  localparam logic [K_W-1:0]    SIZE_RST = K_W'(2);
  localparam logic [CFG_DW-1:0] LOW_RST  = 64'h0000_0000_0000_3130;
  localparam logic [CFG_DW-1:0] HIGH_RST = 64'h0;

  typedef struct packed {
    logic [DIG_W-1:0] rem;
    logic [SLICE-1:0] quo;
  } div_slice_t;

  // SLICE restoring steps of a division by a small k; remainder stays below k.
  function automatic div_slice_t div_slice(input logic [DIG_W-1:0] r_in,
                                           input logic [SLICE-1:0] bits,
                                           input logic [K_W-1:0]   k);
    logic [DIG_W:0]   t;
    logic [DIG_W-1:0] r;
    div_slice_t       res;
    r   = r_in;
    res = '0;
    for (int j = SLICE - 1; j >= 0; j--) begin
      t = {r, bits[j]};
      if (t >= (DIG_W + 1)'(k)) begin
        r          = DIG_W'(t - (DIG_W + 1)'(k));
        res.quo[j] = 1'b1;
      end else begin
        r          = t[DIG_W-1:0];
        res.quo[j] = 1'b0;
      end
    end
    res.rem = r;
    return res;
  endfunction

  function automatic logic [SYM_W-1:0] symbol_of(input logic [DIG_W-1:0]  d,
                                                 input logic [CFG_DW-1:0] lo,
                                                 input logic [CFG_DW-1:0] hi);
    logic [2*CFG_DW-1:0] tbl;
    logic [6:0]          base;
    tbl  = {hi, lo};
    base = 7'(d) << 3;
    return tbl[base +: SYM_W];
  endfunction

endpackage

[design/shortlex_index_to_word.sv]
// Top level: shortlex index to word over a configurable alphabet.
// Usage:
//   in_tdata carries a 48-bit index n. The block answers with the n-th word in
//   shortlex order, one symbol byte per out word, leftmost symbol first; the
//   final word of an index has out_tlast set. Index 0 yields a single word
//   with out_tuser set (empty word), symbol zero and out_tlast set.
//   The APB port holds alphabet_size (0x00), alphabet_low (0x08) and
//   alphabet_high (0x10); write it only while the block is idle.
// Steps for one index:
//   accept, then length search (one add, compare and multiply by k per cycle),
//   then one division per digit in the shared divider (8 quotient bits per
//   cycle over the 48-bit dividend), then per symbol out a digit stack read,
//   a symbol lookup and the present. The input is not ready until the last
//   symbol of the previous index has been taken.
// Reset clears the sequencer and output valid and loads the alphabet
// registers with k = 2 and symbols '0', '1'. When the receiver stalls the
// current out word holds and the sequencer waits.
`include "shortlex_index_to_word_macros.svh"

module shortlex_index_to_word (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [slw_pkg::INDEX_BITS-1:0]    in_tdata,    // [47:0] index
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [slw_pkg::SYM_W-1:0]         out_tdata,   // [7:0] symbol
  output logic                              out_tuser,   // [0] empty_word
  output logic                              out_tlast,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [slw_pkg::CFG_AW-1:0]        cfg_paddr,
  input  logic [slw_pkg::CFG_DW-1:0]        cfg_pwdata,
  output logic [slw_pkg::CFG_DW-1:0]        cfg_prdata,
  output logic                              cfg_pready
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_DIV,
    ST_FETCH,
    ST_LOAD,
    ST_WAIT
  } state_t;

  state_t state_r, state_nxt;

  logic [slw_pkg::K_W-1:0]    size_r;
  logic [slw_pkg::CFG_DW-1:0] alpha_lo_r, alpha_hi_r;
  logic [slw_pkg::K_W-1:0]    k_eff;

  logic [slw_pkg::INDEX_BITS-1:0] n_r, n_nxt;
  logic [slw_pkg::INDEX_BITS-1:0] off_r, off_nxt;
  logic [slw_pkg::PW_W-1:0]       pw_r, pw_nxt;
  logic [slw_pkg::LEN_W-1:0]      len_r, len_nxt;
  logic [slw_pkg::DIV_W-1:0]      dv_r, dv_nxt;
  logic [slw_pkg::DIG_W-1:0]      rem_r, rem_nxt;
  logic [slw_pkg::STEP_W-1:0]     step_r, step_nxt;
  logic [slw_pkg::POS_W-1:0]      ptr_r, ptr_nxt;

  logic                           out_valid_r, out_valid_nxt;
  logic [slw_pkg::SYM_W-1:0]      out_sym_r, out_sym_nxt;
  logic                           out_empty_r, out_empty_nxt;
  logic                           out_last_r, out_last_nxt;

  logic [slw_pkg::PW_W:0]           sum;
  logic                             fits;
  logic [slw_pkg::PW_W+slw_pkg::K_W-1:0] prod;
  slw_pkg::div_slice_t              slice;
  logic                             dig_we;
  logic [slw_pkg::DIG_W-1:0]        dig_mem [slw_pkg::INDEX_BITS];
  logic [slw_pkg::DIG_W-1:0]        dig_q_r;
  logic                             cfg_wr;

  // Configuration
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r     <= slw_pkg::SIZE_RST;
      alpha_lo_r <= slw_pkg::LOW_RST;
      alpha_hi_r <= slw_pkg::HIGH_RST;
    end else if (cfg_wr) begin
      case (cfg_paddr[4:3])
        slw_pkg::REG_ALPHABET_SIZE: size_r     <= cfg_pwdata[slw_pkg::K_W-1:0];
        slw_pkg::REG_ALPHABET_LOW:  alpha_lo_r <= cfg_pwdata;
        slw_pkg::REG_ALPHABET_HIGH: alpha_hi_r <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[4:3])
      slw_pkg::REG_ALPHABET_SIZE: cfg_prdata = slw_pkg::CFG_DW'(size_r);
      slw_pkg::REG_ALPHABET_LOW:  cfg_prdata = alpha_lo_r;
      slw_pkg::REG_ALPHABET_HIGH: cfg_prdata = alpha_hi_r;
      default:                    cfg_prdata = '0;
    endcase
  end

  always_comb begin
    if (size_r < slw_pkg::K_W'(2)) begin
      k_eff = slw_pkg::K_W'(2);
    end else if (size_r > slw_pkg::K_W'(slw_pkg::MAX_ALPHABET)) begin
      k_eff = slw_pkg::K_W'(slw_pkg::MAX_ALPHABET);
    end else begin
      k_eff = size_r;
    end
  end

  // Shared datapath: length-search adder/multiplier and divider slice
  assign sum   = (slw_pkg::PW_W + 1)'(off_r) + (slw_pkg::PW_W + 1)'(pw_r);
  assign fits  = (len_r < slw_pkg::LEN_W'(slw_pkg::INDEX_BITS)) &&
                 (sum <= (slw_pkg::PW_W + 1)'(n_r));
  assign prod  = pw_r * k_eff;
  assign slice = slw_pkg::div_slice(rem_r, dv_r[slw_pkg::DIV_W-1 -: slw_pkg::SLICE], k_eff);
  assign dig_we = (state_r == ST_DIV) &&
                  (step_r == slw_pkg::STEP_W'(slw_pkg::DIV_CYCLES - 1));

  // Digit stack: written low digit first, read back high digit first
  always_ff @(posedge clk) begin
    if (dig_we) begin
      dig_mem[ptr_r] <= slice.rem;
    end
    dig_q_r <= dig_mem[ptr_r];
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_sym_r;
  assign out_tuser  = out_empty_r;
  assign out_tlast  = out_last_r;

  always_comb begin
    state_nxt     = state_r;
    n_nxt         = n_r;
    off_nxt       = off_r;
    pw_nxt        = pw_r;
    len_nxt       = len_r;
    dv_nxt        = dv_r;
    rem_nxt       = rem_r;
    step_nxt      = step_r;
    ptr_nxt       = ptr_r;
    out_valid_nxt = out_valid_r;
    out_sym_nxt   = out_sym_r;
    out_empty_nxt = out_empty_r;
    out_last_nxt  = out_last_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          n_nxt   = in_tdata;
          off_nxt = '0;
          pw_nxt  = slw_pkg::PW_W'(1);
          len_nxt = '0;
          if (in_tdata == '0) begin
            out_valid_nxt = 1'b1;
            out_sym_nxt   = '0;
            out_empty_nxt = 1'b1;
            out_last_nxt  = 1'b1;
            state_nxt     = ST_WAIT;
          end else begin
            state_nxt = ST_SEARCH;
          end
        end
      end
      ST_SEARCH: begin
        if (fits) begin
          off_nxt = off_r + pw_r[slw_pkg::INDEX_BITS-1:0];
          pw_nxt  = prod[slw_pkg::PW_W-1:0];
          len_nxt = len_r + slw_pkg::LEN_W'(1);
        end else begin
          dv_nxt    = slw_pkg::DIV_W'(n_r - off_r);
          rem_nxt   = '0;
          step_nxt  = '0;
          ptr_nxt   = '0;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        dv_nxt  = {dv_r[slw_pkg::DIV_W-slw_pkg::SLICE-1:0], slice.quo};
        rem_nxt = slice.rem;
        if (dig_we) begin
          rem_nxt  = '0;
          step_nxt = '0;
          if (slw_pkg::LEN_W'(ptr_r) + slw_pkg::LEN_W'(1) == len_r) begin
            state_nxt = ST_FETCH;
          end else begin
            ptr_nxt = ptr_r + slw_pkg::POS_W'(1);
          end
        end else begin
          step_nxt = step_r + slw_pkg::STEP_W'(1);
        end
      end
      ST_FETCH: begin
        state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        out_valid_nxt = 1'b1;
        out_sym_nxt   = slw_pkg::symbol_of(dig_q_r, alpha_lo_r, alpha_hi_r);
        out_empty_nxt = 1'b0;
        out_last_nxt  = (ptr_r == '0);
        state_nxt     = ST_WAIT;
      end
      ST_WAIT: begin
        if (out_tready) begin
          out_valid_nxt = 1'b0;
          if (out_last_r) begin
            state_nxt = ST_IDLE;
          end else begin
            ptr_nxt   = ptr_r - slw_pkg::POS_W'(1);
            state_nxt = ST_FETCH;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      out_empty_r <= 1'b0;
      out_last_r  <= 1'b0;
      len_r       <= '0;
      step_r      <= '0;
      ptr_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      out_empty_r <= out_empty_nxt;
      out_last_r  <= out_last_nxt;
      len_r       <= len_nxt;
      step_r      <= step_nxt;
      ptr_r       <= ptr_nxt;
    end
    n_r       <= n_nxt;
    off_r     <= off_nxt;
    pw_r      <= pw_nxt;
    dv_r      <= dv_nxt;
    rem_r     <= rem_nxt;
    out_sym_r <= out_sym_nxt;
  end

  `SLW_ASSERT_CLK(a_no_accept_while_out, !(in_tready && out_tvalid), "ready while word pending")
  `SLW_ASSERT_CLK(a_empty_is_last, out_tuser |-> out_tlast && out_tdata == '0, "bad empty word")
  `SLW_ASSERT_CLK(a_idle_after_last, out_tvalid && out_tready && out_tlast |=> in_tready, "not idle")
  `SLW_ASSERT_CLK(a_len_bound, len_r <= slw_pkg::LEN_W'(slw_pkg::INDEX_BITS), "length overflow")

endmodule

[verif/tb_shortlex_index_to_word.sv]
// Testbench for shortlex_index_to_word: random and directed indexes checked against a predictor.
`timescale 1ns / 1ps

module tb_shortlex_index_to_word;

  localparam logic [1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic [slw_pkg::SYM_W-1:0] symbol;
    logic                      empty_word;
    logic                      last;
  } symbol_word_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_tvalid = 1'b0;
  logic                           in_tready;
  logic [slw_pkg::INDEX_BITS-1:0] in_tdata = '0;
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  logic [slw_pkg::SYM_W-1:0]      out_tdata;
  logic                           out_tuser;
  logic                           out_tlast;
  logic                           cfg_psel = 1'b0;
  logic                           cfg_penable = 1'b0;
  logic                           cfg_pwrite = 1'b0;
  logic [slw_pkg::CFG_AW-1:0]     cfg_paddr = '0;
  logic [slw_pkg::CFG_DW-1:0]     cfg_pwdata = '0;
  logic [slw_pkg::CFG_DW-1:0]     cfg_prdata;
  logic                           cfg_pready;

  // alphabet registers as the block should hold them
  logic [4:0]                     size_reg = 5'd2;
  logic [slw_pkg::CFG_DW-1:0]     low_reg  = 64'h3130;
  logic [slw_pkg::CFG_DW-1:0]     high_reg = 64'h0;

  symbol_word_t                   pending_symbols[$];
  int                             error_count = 0;
  int                             gap_pct = 8;

  shortlex_index_to_word dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),     // [47:0] index
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),    // [7:0] symbol
    .out_tuser   (out_tuser),    // [0] empty_word
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #10_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic void note_error(input string msg);
    error_count++;
    if (error_count <= 10) $display("%s", msg);
  endfunction

  // Expected symbol words for one index under the current alphabet.
  function automatic void spell_word(input logic [slw_pkg::INDEX_BITS-1:0] idx);
    longint unsigned n;
    longint unsigned k;
    longint unsigned off;
    longint unsigned pw;
    longint unsigned rem;
    logic [2*slw_pkg::CFG_DW-1:0] sym_bank;
    int unsigned digits[slw_pkg::INDEX_BITS];
    int len;
    symbol_word_t w;
    n   = longint'(idx);
    k   = size_reg;
    off = 0;
    pw  = 1;
    len = 0;
    sym_bank = {high_reg, low_reg};
    if (k < 2) k = 2;
    if (k > slw_pkg::MAX_ALPHABET) k = slw_pkg::MAX_ALPHABET;
    if (n == 0) begin
      w = '{symbol: '0, empty_word: 1'b1, last: 1'b1};
      pending_symbols.push_back(w);
      return;
    end
    while (len < slw_pkg::INDEX_BITS && off + pw <= n) begin
      off += pw;
      pw  *= k;
      len++;
    end
    rem = n - off;
    for (int i = len - 1; i >= 0; i--) begin
      digits[i] = int'(rem % k);
      rem /= k;
    end
    for (int i = 0; i < len; i++) begin
      w.symbol     = sym_bank[8 * digits[i] +: slw_pkg::SYM_W];
      w.empty_word = 1'b0;
      w.last       = (i == len - 1);
      pending_symbols.push_back(w);
    end
  endfunction

  function automatic logic [slw_pkg::INDEX_BITS-1:0] pick_index();
    logic [63:0] r;
    r = {$urandom, $urandom};
    case ($urandom_range(0, 7))
      0: return '0;
      1: return slw_pkg::INDEX_BITS'($urandom_range(1, 300));
      default: return r[slw_pkg::INDEX_BITS-1:0] >> $urandom_range(0, slw_pkg::INDEX_BITS - 1);
    endcase
  endfunction

  task automatic send_index(input logic [slw_pkg::INDEX_BITS-1:0] idx);
    while (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= idx;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    spell_word(idx);
  endtask

  task automatic wait_words_done();
    in_tvalid <= 1'b0;
    while (pending_symbols.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_register(input logic [1:0] reg_index,
                                input logic [slw_pkg::CFG_DW-1:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {reg_index, 3'b000};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    case (reg_index)
      slw_pkg::REG_ALPHABET_SIZE: size_reg = value[4:0];
      slw_pkg::REG_ALPHABET_LOW:  low_reg  = value;
      slw_pkg::REG_ALPHABET_HIGH: high_reg = value;
      default: ;
    endcase
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_alphabet(input logic [4:0] k, input logic [slw_pkg::CFG_DW-1:0] lo,
                              input logic [slw_pkg::CFG_DW-1:0] hi);
    write_register(slw_pkg::REG_ALPHABET_SIZE, slw_pkg::CFG_DW'(k));
    write_register(slw_pkg::REG_ALPHABET_LOW, lo);
    write_register(slw_pkg::REG_ALPHABET_HIGH, hi);
  endtask

  // binary alphabet out of reset, shortest and longest words
  task automatic test_reset_alphabet();
    send_index('0);
    send_index(48'd1);
    send_index(48'd2);
    send_index(48'd6);
    send_index({slw_pkg::INDEX_BITS{1'b1}} - 1);
    send_index({slw_pkg::INDEX_BITS{1'b1}});
    wait_words_done();
  endtask

  // clamping of out-of-range sizes and full sixteen-symbol alphabet
  task automatic test_alphabet_sizes();
    set_alphabet(5'd16, {$urandom, $urandom}, {$urandom, $urandom});
    send_index(48'd15);
    send_index(48'd16);
    send_index(48'd17);
    send_index({slw_pkg::INDEX_BITS{1'b1}});
    wait_words_done();
    write_register(slw_pkg::REG_ALPHABET_SIZE, slw_pkg::CFG_DW'(0));
    send_index(48'd5);
    wait_words_done();
    write_register(slw_pkg::REG_ALPHABET_SIZE, slw_pkg::CFG_DW'(1));
    send_index(48'd5);
    wait_words_done();
    write_register(slw_pkg::REG_ALPHABET_SIZE, slw_pkg::CFG_DW'(17));
    send_index({slw_pkg::INDEX_BITS{1'b1}});
    send_index(48'd300);
    wait_words_done();
    write_register(slw_pkg::REG_ALPHABET_SIZE, {{(slw_pkg::CFG_DW - 5){1'b1}}, 5'd31});
    send_index(48'd16);
    wait_words_done();
  endtask

  // symbol byte extremes, reaching into the high bank
  task automatic test_symbol_bytes();
    set_alphabet(5'd9, {slw_pkg::CFG_DW{1'b1}}, '0);
    send_index(48'd9);
    send_index(48'd1);
    wait_words_done();
  endtask

  // a write past the last register must not disturb the alphabet
  task automatic test_unused_register();
    write_register(REG_UNUSED, {$urandom, $urandom});
    send_index(48'd12345);
    wait_words_done();
  endtask

  task automatic test_random_words();
    logic [4:0] k;
    for (int phase = 0; phase < 6; phase++) begin
      k = ($urandom_range(0, 7) == 0) ? 5'($urandom_range(0, 31))
                                      : 5'($urandom_range(2, 16));
      set_alphabet(k, {$urandom, $urandom}, {$urandom, $urandom});
      gap_pct = (phase == 3) ? 0 : 8;
      for (int i = 0; i < 50; i++) begin
        send_index(pick_index());
        if (phase == 1 && i == 25) wait_words_done();
      end
      wait_words_done();
    end
    gap_pct = 8;
  endtask

  always @(posedge clk) begin
    symbol_word_t want;
    out_tready <= (gap_pct == 0) || ($urandom_range(0, 99) >= gap_pct);
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_symbols.size() == 0) begin
        note_error($sformatf("unexpected word: symbol %h empty %b last %b",
                             out_tdata, out_tuser, out_tlast));
      end else begin
        want = pending_symbols.pop_front();
        if (out_tdata !== want.symbol || out_tuser !== want.empty_word ||
            out_tlast !== want.last) begin
          note_error($sformatf(
            "mismatch: symbol exp %h got %h, empty exp %b got %b, last exp %b got %b",
            want.symbol, out_tdata, want.empty_word, out_tuser, want.last, out_tlast));
        end
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_alphabet();
    test_alphabet_sizes();
    test_symbol_bytes();
    test_unused_register();
    test_random_words();
    wait_words_done();
    repeat (20) @(posedge clk);
    if (pending_symbols.size() != 0) note_error("words still expected at end of run");
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
